@@ src/fmpc_pkg.sv @@
// fmpc_pkg: shared types, constants and helpers of the flow meter pulse counter
// no dependencies; imported by flow_meter_pulse_counter_unit
`default_nettype none

package fmpc_pkg;

  localparam int unsigned CountW    = 32;
  localparam int unsigned DebounceW = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned InDataW   = 40;  // level_a, level_b, now_us, zero fill
  localparam int unsigned OutDataW  = 72;  // pulse_count, reverse_depth, stop_event, stopped

  localparam logic                 PresetModeRst = 1'b1;
  localparam logic [CountW-1:0]    TargetRst     = '0;
  localparam logic [DebounceW-1:0] DebounceRst   = 16'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRESET_MODE   = 2'd0,
    CFG_TARGET_PULSES = 2'd1,
    CFG_DEBOUNCE_US   = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_EDGE_A = 1'b0,
    CMD_EDGE_B = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_A_BOTH_HIGH = 2'd0,
    KIND_A_OTHER     = 2'd1,
    KIND_B_ONLY_HIGH = 2'd2,
    KIND_B_OTHER     = 2'd3
  } edge_kind_e;

  typedef struct packed {
    logic              stopped;
    logic              stop_event;
    logic [CountW-1:0] reverse_depth;
    logic [CountW-1:0] pulse_count;
  } result_t;

  // wrapping timestamp distance against the debounce window
  function automatic logic waited(input logic [CountW-1:0] now,
                                  input logic [CountW-1:0] then_us,
                                  input logic [DebounceW-1:0] window);
    logic [CountW-1:0] diff;
    diff = now - then_us;
    return diff >= {{(CountW-DebounceW){1'b0}}, window};
  endfunction

endpackage

`default_nettype wire

@@ src/flow_meter_pulse_counter_unit.sv @@
// flow meter pulse counter: an input beat passes the input register, then the counter
// update and the result register, before it leaves as a result beat; throughput one
// beat per cycle while the result side is ready. reverse and debounce checks,
// the count increment and the target compare all sit between those two registers.
// reset (rst_ni low, asynchronous) clears all counters, timestamps, levels and the
// stop flag; registers return to preset mode on, target 0, debounce 1000 us
// file: top level; depends on fmpc_pkg
`default_nettype none

module flow_meter_pulse_counter_unit (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // configuration writes
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [fmpc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire [fmpc_pkg::CfgDataW-1:0] cfg_data_i,
  // edge events
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire [fmpc_pkg::InDataW-1:0]  s_axis_tdata,  // [0] level_a, [1] level_b, [33:2] now_us
  input  wire                          s_axis_tuser,  // [0] command
  // results
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [fmpc_pkg::OutDataW-1:0] m_axis_tdata  // [31:0] pulse_count,
                                                      // [63:32] reverse_depth,
                                                      // [64] stop_event, [65] stopped
);

  import fmpc_pkg::*;

  // configuration
  logic                 preset_mode_q;
  logic [CountW-1:0]    target_pulses_q;
  logic [DebounceW-1:0] debounce_us_q;

  // input register
  logic              in_valid_q;
  logic              in_cmd_q;
  logic              in_a_q;
  logic              in_b_q;
  logic [CountW-1:0] in_now_q;

  // block state
  logic [CountW-1:0] pulse_count_q, pulse_count_d;
  logic [CountW-1:0] reverse_fwd_q, reverse_fwd_d;
  logic [CountW-1:0] reverse_back_q, reverse_back_d;
  logic [CountW-1:0] edge_times_q [4];
  logic [CountW-1:0] reverse_times_q [2];
  logic              last_a_q;
  logic              last_b_q;
  logic              stopped_q;

  // result register
  logic    out_valid_q;
  result_t out_q, out_d;

  logic       advance;
  logic       rev_hit_a, rev_hit_b;
  logic       lvl_change, fwd_try, fwd_ok, hit_target, stop_now;
  edge_kind_e kind;

  assign cfg_ready_o   = 1'b1;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-$bits(result_t)){1'b0}}, out_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preset_mode_q   <= PresetModeRst;
      target_pulses_q <= TargetRst;
      debounce_us_q   <= DebounceRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PRESET_MODE:   preset_mode_q   <= cfg_data_i[0];
        CFG_TARGET_PULSES: target_pulses_q <= cfg_data_i[CountW-1:0];
        CFG_DEBOUNCE_US:   debounce_us_q   <= cfg_data_i[DebounceW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q <= s_axis_tuser;
      in_a_q   <= s_axis_tdata[0];
      in_b_q   <= s_axis_tdata[1];
      in_now_q <= s_axis_tdata[CountW+1:2];
    end
  end

  // reverse tracking, then the forward edge sees the updated counters
  always_comb begin
    rev_hit_a = (in_cmd_q == CMD_EDGE_A) && in_a_q && !in_b_q &&
                waited(in_now_q, reverse_times_q[0], debounce_us_q);
    rev_hit_b = (in_cmd_q == CMD_EDGE_B) && !in_a_q && in_b_q &&
                waited(in_now_q, reverse_times_q[1], debounce_us_q);

    reverse_fwd_d  = reverse_fwd_q;
    reverse_back_d = reverse_back_q;
    if (rev_hit_a) begin
      reverse_fwd_d  = reverse_fwd_q + 1'b1;
      reverse_back_d = reverse_fwd_q + 1'b1;
    end else if (rev_hit_b) begin
      if (reverse_back_q != '0) begin
        reverse_back_d = reverse_back_q - 1'b1;
      end else begin
        reverse_fwd_d = '0;
      end
    end

    if (in_cmd_q == CMD_EDGE_A) begin
      lvl_change = in_a_q != last_a_q;
      kind       = (in_a_q && in_b_q) ? KIND_A_BOTH_HIGH : KIND_A_OTHER;
    end else begin
      lvl_change = in_b_q != last_b_q;
      kind       = (!in_a_q && in_b_q) ? KIND_B_ONLY_HIGH : KIND_B_OTHER;
    end

    fwd_try    = lvl_change && (reverse_back_d == '0) && (reverse_fwd_d == '0);
    fwd_ok     = fwd_try && waited(in_now_q, edge_times_q[kind], debounce_us_q);
    hit_target = preset_mode_q && (pulse_count_q >= target_pulses_q);
    stop_now   = fwd_ok && hit_target;

    pulse_count_d = pulse_count_q;
    if (fwd_ok && !hit_target) begin
      pulse_count_d = pulse_count_q + 1'b1;
    end

    // a stopped unit holds everything
    if (stopped_q) begin
      out_d.pulse_count   = pulse_count_q;
      out_d.reverse_depth = reverse_back_q;
      out_d.stop_event    = 1'b0;
      out_d.stopped       = 1'b1;
    end else begin
      out_d.pulse_count   = pulse_count_d;
      out_d.reverse_depth = reverse_back_d;
      out_d.stop_event    = stop_now;
      out_d.stopped       = stop_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_count_q      <= '0;
      reverse_fwd_q      <= '0;
      reverse_back_q     <= '0;
      edge_times_q       <= '{default: '0};
      reverse_times_q    <= '{default: '0};
      last_a_q           <= 1'b0;
      last_b_q           <= 1'b0;
      stopped_q          <= 1'b0;
    end else if (advance && !stopped_q) begin
      pulse_count_q  <= pulse_count_d;
      reverse_fwd_q  <= reverse_fwd_d;
      reverse_back_q <= reverse_back_d;
      if (rev_hit_a) begin
        reverse_times_q[0] <= in_now_q;
      end
      if (rev_hit_b) begin
        reverse_times_q[1] <= in_now_q;
      end
      if (fwd_ok) begin
        edge_times_q[kind] <= in_now_q;
      end
      if (fwd_try) begin
        if (in_cmd_q == CMD_EDGE_A) begin
          last_a_q <= in_a_q;
        end else begin
          last_b_q <= in_b_q;
        end
      end
      if (stop_now) begin
        stopped_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |=> stopped_q)
    else $error("stop flag cleared without reset");

  a_count_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |=> $stable(pulse_count_q))
    else $error("pulse count moved after stop");

  a_rev_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reverse_back_q <= reverse_fwd_q)
    else $error("reverse depth exceeds reverse edge count");

  a_stop_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.stop_event |-> out_q.stopped)
    else $error("stop beat without stopped flag");

  a_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_now_q))
    else $error("pending event lost while stalled");
`endif

endmodule

`default_nettype wire
